// ----- hw/rtl/shift_register_rng_288_defines.svh -----
// assertion macros for the shift register generator
`ifndef SHIFT_REGISTER_RNG_288_DEFINES_SVH
`define SHIFT_REGISTER_RNG_288_DEFINES_SVH

`ifndef SYNTHESIS
`define SRR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("srr assertion failed");
`define SRR_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("srr forbidden condition");
`else
`define SRR_ASSERT(lbl, clk, rst_n, prop)
`define SRR_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ----- hw/rtl/srr_pkg.sv -----
package srr_pkg;

  localparam int WordW    = 32;
  localparam int NumWords = 9;
  localparam int IdxW     = 4;
  localparam int ValW     = 54;
  localparam int OpW      = 2;
  localparam int CntW     = 4;

  localparam logic [WordW-1:0] SeedMul     = 32'd69607;
  localparam logic [WordW-1:0] SeedInc     = 32'd54329;
  localparam logic [WordW-1:0] SeedDefault = 32'd32767;
  localparam logic [WordW-1:0] MixMask     = 32'h0000_7ffc;

  localparam logic [IdxW-1:0] IdxFull  = 4'(NumWords);
  localparam logic [CntW-1:0] LastStep = 4'(NumWords - 1);

  typedef enum logic [OpW-1:0] {
    OP_WORD = 2'd0,
    OP_FRAC = 2'd1,
    OP_SEED = 2'd2
  } op_e;

  typedef struct packed {
    logic shift;
    logic seed_mode;
    logic lcg_load;
  } ring_ctrl_t;

  function automatic logic [WordW-1:0] mix_word(input logic [WordW-1:0] a,
                                                input logic [WordW-1:0] b,
                                                input logic [WordW-1:0] c);
    logic [WordW-1:0] left;
    logic [WordW-1:0] rot;
    left = ((b << 2) & MixMask) | ((a << 2) & ~MixMask) | (a >> 30);
    rot  = {c[WordW-2:0], c[WordW-1]};
    return left ^ rot;
  endfunction

endpackage

// ----- hw/rtl/srr_cell.sv -----
module srr_cell (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [srr_pkg::WordW-1:0]    d_i,
  output logic [srr_pkg::WordW-1:0]    q_o
);

  logic [srr_pkg::WordW-1:0] word_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= d_i;
    end
  end

  assign q_o = word_q;

endmodule

// ----- hw/rtl/srr_ring.sv -----
module srr_ring (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  srr_pkg::ring_ctrl_t          ctrl_i,
  input  logic [srr_pkg::WordW-1:0]    seed_i,
  input  logic [srr_pkg::IdxW-1:0]     rd_idx_i,
  output logic [srr_pkg::WordW-1:0]    rd_word_o
);

  logic [srr_pkg::WordW-1:0] word_w [srr_pkg::NumWords];
  logic [srr_pkg::WordW-1:0] feed_w [srr_pkg::NumWords];
  logic [srr_pkg::WordW-1:0] lcg_q, lcg_d;

  // ring rotates toward cell 0; the active step always sits at cell 0
  always_comb begin
    for (int i = 0; i < srr_pkg::NumWords - 1; i++) begin
      feed_w[i] = word_w[i+1];
    end
    if (ctrl_i.seed_mode) begin
      feed_w[srr_pkg::NumWords-1] = lcg_q;
    end else begin
      feed_w[0] = word_w[1] ^ word_w[0];
      feed_w[srr_pkg::NumWords-1] = srr_pkg::mix_word(word_w[2], word_w[3], word_w[0]);
    end
  end

  for (genvar g = 0; g < srr_pkg::NumWords; g++) begin : g_cell
    srr_cell u_cell (
      .clk_i (clk_i),
      .en_i  (ctrl_i.shift),
      .d_i   (feed_w[g]),
      .q_o   (word_w[g])
    );
  end

  always_comb begin
    lcg_d = lcg_q;
    if (ctrl_i.lcg_load) begin
      lcg_d = (seed_i == '0) ? srr_pkg::SeedDefault : seed_i;
    end else if (ctrl_i.shift && ctrl_i.seed_mode) begin
      lcg_d = 32'(lcg_q * srr_pkg::SeedMul + srr_pkg::SeedInc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcg_q <= srr_pkg::SeedDefault;
    end else begin
      lcg_q <= lcg_d;
    end
  end

  assign rd_word_o = word_w[rd_idx_i];

endmodule

// ----- hw/rtl/shift_register_rng_288.sv -----
// word draw: ST_RD1 loads the result; ST_ADV runs first when the ring must advance
// fraction draw: ST_RD1, ST_RD2; ST_ADV (9 cell steps) first if the ring must advance
// reseed: no result; the ring shifts in one seed word per cycle
// reset seeds the ring with 32767 in ST_SEED, in_ready_o low meanwhile
// one word in flight; the next is accepted while a result waits in the output register
`include "shift_register_rng_288_defines.svh"

module shift_register_rng_288 (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [srr_pkg::OpW-1:0]      op_i,
  input  logic [srr_pkg::WordW-1:0]    seed_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [srr_pkg::ValW-1:0]     value_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ADV  = 5'b00010,
    ST_SEED = 5'b00100,
    ST_RD1  = 5'b01000,
    ST_RD2  = 5'b10000
  } state_e;

  state_e                      state_q, state_d;
  logic [srr_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [srr_pkg::IdxW-1:0]    idx_q, idx_d;
  logic                        frac_q, frac_d;
  logic [srr_pkg::WordW-1:0]   hi_q, hi_d;
  logic                        out_valid_q, out_valid_d;
  logic [srr_pkg::ValW-1:0]    value_q, value_d;
  srr_pkg::ring_ctrl_t         ring_ctrl;
  logic [srr_pkg::WordW-1:0]   rd_word;
  logic                        out_free;

  srr_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ring_ctrl),
    .seed_i    (seed_i),
    .rd_idx_i  (idx_q - 4'd1),
    .rd_word_o (rd_word)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    frac_d      = frac_q;
    hi_d        = hi_q;
    out_valid_d = out_valid_q && !out_ready_i;
    value_d     = value_q;
    ring_ctrl   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cnt_d = '0;
          case (srr_pkg::op_e'(op_i))
            srr_pkg::OP_WORD: begin
              frac_d  = 1'b0;
              state_d = (idx_q <= 4'd1) ? ST_ADV : ST_RD1;
            end
            srr_pkg::OP_FRAC: begin
              frac_d  = 1'b1;
              state_d = (idx_q <= 4'd2) ? ST_ADV : ST_RD1;
            end
            srr_pkg::OP_SEED: begin
              ring_ctrl.lcg_load = 1'b1;
              state_d            = ST_SEED;
            end
            default: ;
          endcase
        end
      end
      ST_ADV: begin
        ring_ctrl.shift = 1'b1;
        cnt_d           = cnt_q + 4'd1;
        if (cnt_q == srr_pkg::LastStep) begin
          cnt_d   = '0;
          idx_d   = srr_pkg::IdxFull;
          state_d = ST_RD1;
        end
      end
      ST_SEED: begin
        ring_ctrl.shift     = 1'b1;
        ring_ctrl.seed_mode = 1'b1;
        cnt_d               = cnt_q + 4'd1;
        if (cnt_q == srr_pkg::LastStep) begin
          cnt_d   = '0;
          idx_d   = srr_pkg::IdxFull;
          state_d = ST_IDLE;
        end
      end
      ST_RD1: begin
        if (frac_q) begin
          hi_d    = rd_word;
          idx_d   = idx_q - 4'd1;
          state_d = ST_RD2;
        end else if (out_free) begin
          value_d     = {{(srr_pkg::ValW - srr_pkg::WordW){1'b0}}, rd_word};
          out_valid_d = 1'b1;
          idx_d       = idx_q - 4'd1;
          state_d     = ST_IDLE;
        end
      end
      ST_RD2: begin
        if (out_free) begin
          value_d     = {hi_q, rd_word[31:11], 1'b1};
          out_valid_d = 1'b1;
          idx_d       = idx_q - 4'd1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SEED;
      cnt_q       <= '0;
      idx_q       <= srr_pkg::IdxFull;
      frac_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      frac_q      <= frac_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q    <= hi_d;
    value_q <= value_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

  `SRR_ASSERT(a_rd1_idx, clk_i, rst_ni, (state_q == ST_RD1) |-> (idx_q != 4'd0 && idx_q <= srr_pkg::IdxFull))
  `SRR_ASSERT(a_rd2_idx, clk_i, rst_ni, (state_q == ST_RD2) |-> (frac_q && idx_q >= 4'd1))
  `SRR_ASSERT(a_adv_end, clk_i, rst_ni, (state_q == ST_ADV && cnt_q == srr_pkg::LastStep) |=> (state_q == ST_RD1 && idx_q == srr_pkg::IdxFull))
  `SRR_ASSERT(a_seed_go, clk_i, rst_ni, (in_valid_i && in_ready_o && op_i == srr_pkg::OP_SEED) |=> (state_q == ST_SEED && cnt_q == 4'd0))
  `SRR_NEVER(a_idle_cnt, clk_i, rst_ni, state_q == ST_IDLE && cnt_q != 4'd0)

endmodule

// ----- bench/shift_register_rng_288_test.sv -----
`timescale 1ns / 1ps

module shift_register_rng_288_test;

  localparam logic [srr_pkg::OpW-1:0] OpIgnored = 2'd3;
  localparam int CycleLimit = 300000;
  localparam int TailCycles = 20;
  localparam int RandItems  = 420;
  localparam int NumRows    = 28;

  typedef struct packed {
    logic [srr_pkg::OpW-1:0]   op;
    logic [srr_pkg::WordW-1:0] seed;
    logic                      gives;
  } dir_row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [srr_pkg::OpW-1:0]   op_i;
  logic [srr_pkg::WordW-1:0] seed_i;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [srr_pkg::ValW-1:0]  value_o;

  shift_register_rng_288 u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .seed_i      (seed_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [srr_pkg::WordW-1:0] ring_words [srr_pkg::NumWords];
  int unsigned               ring_idx;
  logic [srr_pkg::ValW-1:0]  pending_values [$];
  dir_row_t                  dir_rows [NumRows];

  int send_idle;
  int recv_idle;
  int mismatches;
  int cycle_count;
  int n_word, n_frac, n_seed, n_ignored, n_advance, n_checked;

  function automatic logic [srr_pkg::WordW-1:0] ring_mix(
      input logic [srr_pkg::WordW-1:0] a,
      input logic [srr_pkg::WordW-1:0] b,
      input logic [srr_pkg::WordW-1:0] c);
    logic [srr_pkg::WordW-1:0] left;
    left = {a[29:13], b[12:0], a[31:30]};
    return left ^ {c[30:0], c[31]};
  endfunction

  task automatic ring_advance();
    logic [srr_pkg::WordW-1:0] w [srr_pkg::NumWords];
    for (int k = 0; k < srr_pkg::NumWords; k++) w[k] = ring_words[k];
    for (int k = 0; k < srr_pkg::NumWords; k++) begin
      w[(k + 1) % srr_pkg::NumWords] ^= w[k];
      w[k] = ring_mix(w[(k + 2) % srr_pkg::NumWords], w[(k + 3) % srr_pkg::NumWords], w[k]);
    end
    for (int k = 0; k < srr_pkg::NumWords; k++) ring_words[k] = w[k];
    ring_idx = srr_pkg::NumWords;
    n_advance++;
  endtask

  task automatic ring_reseed(input logic [srr_pkg::WordW-1:0] seed);
    ring_words[0] = (seed == '0) ? 32'd32767 : seed;
    for (int i = 1; i < srr_pkg::NumWords; i++)
      ring_words[i] = ring_words[i-1] * 32'd69607 + 32'd54329;
    ring_idx = srr_pkg::NumWords;
  endtask

  task automatic rng_predict(input logic [srr_pkg::OpW-1:0] op,
                             input logic [srr_pkg::WordW-1:0] seed,
                             output bit has_val, output logic [srr_pkg::ValW-1:0] val);
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] frac;
    has_val = 1'b0;
    val = '0;
    if (ring_idx > srr_pkg::NumWords) ring_idx = srr_pkg::NumWords;
    if (op == srr_pkg::OP_WORD) begin
      if (ring_idx <= 1) ring_advance();
      ring_idx--;
      val = srr_pkg::ValW'(ring_words[ring_idx]);
      has_val = 1'b1;
      n_word++;
    end else if (op == srr_pkg::OP_FRAC) begin
      if (ring_idx <= 2) ring_advance();
      ring_idx--;
      hi = 64'(ring_words[ring_idx]);
      ring_idx--;
      lo = 64'(ring_words[ring_idx]);
      frac = (((hi << 21) | (lo >> 11)) << 1) | 64'd1;
      val = frac[srr_pkg::ValW-1:0];
      has_val = 1'b1;
      n_frac++;
    end else if (op == srr_pkg::OP_SEED) begin
      ring_reseed(seed);
      n_seed++;
    end else begin
      n_ignored++;
    end
  endtask

  task automatic note_mismatch(input string what, input logic [srr_pkg::ValW-1:0] exp_v,
                               input logic [srr_pkg::ValW-1:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h got %h", what, exp_v, act_v);
  endtask

  // called at a falling edge, returns at the falling edge after the accept
  task automatic drive_word(input logic [srr_pkg::OpW-1:0] op,
                            input logic [srr_pkg::WordW-1:0] seed,
                            input bit check_gives, input bit gives);
    bit                       has_val;
    logic [srr_pkg::ValW-1:0] val;
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    seed_i     <= seed;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    rng_predict(op, seed, has_val, val);
    if (has_val) pending_values.push_back(val);
    if (check_gives && (has_val != gives))
      note_mismatch("result presence", srr_pkg::ValW'(gives), srr_pkg::ValW'(has_val));
    @(negedge clk_i);
  endtask

  task automatic drain_pending();
    in_valid_i <= 1'b0;
    while (pending_values.size() != 0) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    logic [srr_pkg::ValW-1:0] exp_v;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_values.size() == 0) begin
        note_mismatch("unexpected word", '0, value_o);
      end else begin
        exp_v = pending_values.pop_front();
        n_checked++;
        if (value_o !== exp_v) note_mismatch("value", exp_v, value_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("shift_register_rng_288_test: FAIL");
      $finish;
    end
  end

  initial begin
    int                        sent;
    int                        r;
    logic [srr_pkg::OpW-1:0]   op;
    logic [srr_pkg::WordW-1:0] seed;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    op_i        = srr_pkg::OP_WORD;
    seed_i      = '0;
    send_idle   = 8;
    recv_idle   = 66;
    mismatches  = 0;
    cycle_count = 0;
    n_word = 0; n_frac = 0; n_seed = 0; n_ignored = 0; n_advance = 0; n_checked = 0;

    dir_rows = '{
      '{srr_pkg::OP_WORD, 32'h0000_0000, 1'b1},
      '{srr_pkg::OP_FRAC, 32'hffff_ffff, 1'b1},
      '{srr_pkg::OP_WORD, 32'h0000_0000, 1'b1},
      '{srr_pkg::OP_FRAC, 32'h0000_0000, 1'b1},
      '{srr_pkg::OP_WORD, 32'h0000_0000, 1'b1},
      '{OpIgnored,        32'hffff_ffff, 1'b0},
      '{srr_pkg::OP_SEED, 32'h0000_0000, 1'b0},
      '{srr_pkg::OP_FRAC, 32'h0000_0000, 1'b1},
      '{srr_pkg::OP_FRAC, 32'h0000_0000, 1'b1},
      '{srr_pkg::OP_FRAC, 32'h0000_0000, 1'b1},
      '{srr_pkg::OP_FRAC, 32'h0000_0000, 1'b1},
      '{srr_pkg::OP_SEED, 32'hffff_ffff, 1'b0},
      '{srr_pkg::OP_WORD, 32'h0000_0000, 1'b1},
      '{srr_pkg::OP_WORD, 32'hffff_ffff, 1'b1},
      '{srr_pkg::OP_WORD, 32'h0000_0000, 1'b1},
      '{srr_pkg::OP_WORD, 32'h0000_0000, 1'b1},
      '{srr_pkg::OP_WORD, 32'h0000_0000, 1'b1},
      '{srr_pkg::OP_WORD, 32'h0000_0000, 1'b1},
      '{srr_pkg::OP_WORD, 32'h0000_0000, 1'b1},
      '{srr_pkg::OP_WORD, 32'h0000_0000, 1'b1},
      '{srr_pkg::OP_WORD, 32'h0000_0000, 1'b1},
      '{srr_pkg::OP_SEED, 32'h0000_0001, 1'b0},
      '{srr_pkg::OP_WORD, 32'h0000_0000, 1'b1},
      '{srr_pkg::OP_FRAC, 32'h0000_0000, 1'b1},
      '{srr_pkg::OP_FRAC, 32'h0000_0000, 1'b1},
      '{srr_pkg::OP_FRAC, 32'h0000_0000, 1'b1},
      '{OpIgnored,        32'h0000_0000, 1'b0},
      '{srr_pkg::OP_SEED, 32'h8000_0000, 1'b0}
    };

    ring_reseed(32'd32767);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumRows; i++)
      drive_word(dir_rows[i].op, dir_rows[i].seed, 1'b1, dir_rows[i].gives);

    for (int phase = 0; phase < 3; phase++) begin
      // hold off until the block has delivered everything
      drain_pending();
      @(negedge clk_i);
      case (phase)
        0: begin send_idle = 8;  recv_idle = 66; end
        1: begin send_idle = 66; recv_idle = 8;  end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      sent = 0;
      while (sent < RandItems / 3) begin
        r = $urandom_range(99);
        if (r < 46)      op = srr_pkg::OP_WORD;
        else if (r < 82) op = srr_pkg::OP_FRAC;
        else if (r < 94) op = srr_pkg::OP_SEED;
        else             op = OpIgnored;
        r = $urandom_range(9);
        if (r == 0)      seed = '0;
        else if (r == 1) seed = '1;
        else             seed = $urandom;
        drive_word(op, seed, 1'b0, 1'b0);
        sent++;
      end
    end

    drain_pending();
    repeat (TailCycles) @(negedge clk_i);

    $display("covered %0d word draws, %0d fraction draws, %0d reseeds, %0d ignored codes",
             n_word, n_frac, n_seed, n_ignored);
    $display("ring advances %0d, words checked %0d, mismatches %0d",
             n_advance, n_checked, mismatches);
    if (mismatches == 0) begin
      $display("shift_register_rng_288_test: PASS");
    end else begin
      $display("shift_register_rng_288_test: FAIL");
    end
    $finish;
  end

endmodule
